// File: src/ppi_pkg.sv
// Shared types, constants and functions of the planar pose integrator.
package ppi_pkg;

   localparam int CordicSteps = 14;
   localparam int StepBits    = $clog2(CordicSteps + 1);
   localparam int CW          = 20;   // CORDIC x/y width
   localparam int ZW          = 28;   // CORDIC angle width

   localparam logic [14:0] AreaWidthReset  = 15'd2839;
   localparam logic [14:0] AreaHeightReset = 15'd2839;
   localparam logic [15:0] TickLengthReset = 16'd1049;
   localparam logic signed [CW-1:0] GainQ16 = CW'(39797);

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_PLACE  = 2'd1,
      CMD_MOTION = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_TICK   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CORDIC,
      ST_PROD,
      ST_POSE,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture the request beat and apply simple commands
      logic mul;       // form speed products
      logic cdc_init;  // start CORDIC
      logic cdc_step;  // one CORDIC iteration
      logic prod;      // displacement products
      logic pose;      // update pose
      logic show;      // load response register
   } ctrl_type;

   typedef struct packed {
      logic moving_tick;
      logic cdc_done;
   } stat_type;

   function automatic logic signed [ZW:0] atan_turn(input logic [4:0] i);
      case (i)
         5'd0:  atan_turn = 29'sd33554432;
         5'd1:  atan_turn = 29'sd19808338;
         5'd2:  atan_turn = 29'sd10466182;
         5'd3:  atan_turn = 29'sd5312797;
         5'd4:  atan_turn = 29'sd2666708;
         5'd5:  atan_turn = 29'sd1334654;
         5'd6:  atan_turn = 29'sd667490;
         5'd7:  atan_turn = 29'sd333765;
         5'd8:  atan_turn = 29'sd166885;
         5'd9:  atan_turn = 29'sd83443;
         5'd10: atan_turn = 29'sd41721;
         5'd11: atan_turn = 29'sd20861;
         5'd12: atan_turn = 29'sd10430;
         5'd13: atan_turn = 29'sd5215;
         5'd14: atan_turn = 29'sd2608;
         5'd15: atan_turn = 29'sd1304;
         5'd16: atan_turn = 29'sd652;
         5'd17: atan_turn = 29'sd326;
         5'd18: atan_turn = 29'sd163;
         5'd19: atan_turn = 29'sd81;
         default: atan_turn = '0;
      endcase
   endfunction

endpackage

// File: src/ppi_ctrl.sv
// Sequencing state machine of the planar pose integrator.
module ppi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ppi_pkg::stat_type stat,
   output ppi_pkg::ctrl_type ctrl
);
   import ppi_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Hold state and response flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance through the tick sequence
   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = stat.moving_tick ? ST_MUL : ST_RESP;
            end
         end
         ST_MUL: begin
            ctrl.mul      = 1'b1;
            ctrl.cdc_init = 1'b1;
            state_in      = ST_CORDIC;
         end
         ST_CORDIC: begin
            ctrl.cdc_step = 1'b1;
            if (stat.cdc_done) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            ctrl.prod = 1'b1;
            state_in  = ST_POSE;
         end
         ST_POSE: begin
            ctrl.pose = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.show    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_show_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.show |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");
   a_mul_then_cordic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_CORDIC))
      else $error("sequence broken");
`endif
endmodule

// File: src/ppi_dp.sv
// Datapath of the planar pose integrator: state, CORDIC and pose update.
module ppi_dp (
   input  logic              clock,
   input  logic              reset,
   input  ppi_pkg::ctrl_type ctrl,
   output ppi_pkg::stat_type stat,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  logic [1:0]        req_command,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0]       req_heading_in,
   input  logic signed [15:0] req_lin_speed_in,
   input  logic signed [15:0] req_ang_speed_in,
   input  logic [15:0]       req_duration_ticks,
   output logic [14:0]       rsp_x_out,
   output logic [14:0]       rsp_y_out,
   output logic [15:0]       rsp_heading_out,
   output logic signed [15:0] rsp_lin_speed_out,
   output logic signed [15:0] rsp_ang_speed_out,
   output logic              rsp_moving,
   output logic              rsp_wall_hit
);
   import ppi_pkg::*;

   logic [14:0] area_w_ff, area_h_ff;
   logic [15:0] tick_len_ff;
   logic [14:0] pose_x_ff, pose_y_ff, pose_x_in, pose_y_in;
   logic [15:0] heading_ff, heading_in;
   logic signed [15:0] lin_ff, ang_ff, lin_in, ang_in;
   logic [15:0] ticks_ff, ticks_in;
   logic        hit_ff, hit_in;

   logic signed [32:0] d_ff;      // lin * tick_length
   logic signed [32:0] ah_ff;     // ang * tick_length
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [ZW:0]   cz_ff;
   logic [1:0]           quad_ff;
   logic [StepBits-1:0]  step_ff;
   logic signed [53:0]   px_ff, py_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         area_w_ff   <= AreaWidthReset;
         area_h_ff   <= AreaHeightReset;
         tick_len_ff <= TickLengthReset;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:  area_w_ff   <= csr_data[14:0];
            CSR_HEIGHT: area_h_ff   <= csr_data[14:0];
            CSR_TICK:   tick_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic [14:0] clamp(input logic signed [17:0] v,
                                         input logic [14:0] hi);
      if (v < 0) clamp = '0;
      else if (v > $signed({3'b000, hi})) clamp = hi;
      else clamp = v[14:0];
   endfunction

   function automatic logic signed [17:0] rnd32(input logic signed [53:0] p);
      logic signed [53:0] m;
      logic signed [53:0] r;
      m = (p < 0) ? -p : p;
      r = (m + 54'sh80000000) >>> 32;
      rnd32 = (p < 0) ? -r[17:0] : r[17:0];
   endfunction

   logic signed [32:0] ah_abs, ah_rnd;
   logic signed [15:0] dh;
   logic signed [CW-1:0] cxs, cys, cos_v, sin_v;
   logic signed [17:0] nx, ny;
   logic [4:0] step5;

   assign step5  = 5'(step_ff);
   assign cxs    = cx_ff >>> step_ff;
   assign cys    = cy_ff >>> step_ff;
   assign ah_abs = (ah_ff < 0) ? -ah_ff : ah_ff;
   assign ah_rnd = (ah_abs + 33'sd2048) >>> 12;
   assign dh     = (ah_ff < 0) ? -ah_rnd[15:0] : ah_rnd[15:0];
   assign nx     = $signed({3'b000, pose_x_ff}) + rnd32(px_ff);
   assign ny     = $signed({3'b000, pose_y_ff}) + rnd32(py_ff);

   // Rotate CORDIC output into the heading's quadrant
   always_comb begin
      case (quad_ff)
         2'd1:    begin cos_v = -cy_ff; sin_v = cx_ff;  end
         2'd2:    begin cos_v = -cx_ff; sin_v = -cy_ff; end
         2'd3:    begin cos_v = cy_ff;  sin_v = -cx_ff; end
         default: begin cos_v = cx_ff;  sin_v = cy_ff;  end
      endcase
   end

   assign stat.moving_tick = (req_command == CMD_TICK) && (ticks_ff != '0);
   assign stat.cdc_done    = (step_ff == StepBits'(CordicSteps - 1));

   // Next architectural state
   always_comb begin
      pose_x_in  = pose_x_ff;
      pose_y_in  = pose_y_ff;
      heading_in = heading_ff;
      lin_in     = lin_ff;
      ang_in     = ang_ff;
      ticks_in   = ticks_ff;
      hit_in     = hit_ff;
      if (ctrl.load) begin
         hit_in = 1'b0;
         case (cmd_type'(req_command))
            CMD_TICK: begin
               if (ticks_ff == '0) begin
                  lin_in = '0;
                  ang_in = '0;
               end
            end
            CMD_PLACE: begin
               pose_x_in  = clamp(18'(req_pos_x), area_w_ff);
               pose_y_in  = clamp(18'(req_pos_y), area_h_ff);
               heading_in = req_heading_in;
               lin_in     = '0;
               ang_in     = '0;
               ticks_in   = '0;
            end
            CMD_MOTION: begin
               lin_in   = req_lin_speed_in;
               ang_in   = req_ang_speed_in;
               ticks_in = req_duration_ticks;
            end
            default: ;
         endcase
      end
      if (ctrl.pose) begin
         ticks_in   = ticks_ff - 16'd1;
         heading_in = heading_ff + dh;
         hit_in     = (nx < 0) || (nx > $signed({3'b000, area_w_ff})) ||
                      (ny < 0) || (ny > $signed({3'b000, area_h_ff}));
         pose_x_in  = clamp(nx, area_w_ff);
         pose_y_in  = clamp(ny, area_h_ff);
      end
   end

   // Hold architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         heading_ff <= '0;
         lin_ff     <= '0;
         ang_ff     <= '0;
         ticks_ff   <= '0;
         hit_ff     <= 1'b0;
      end else begin
         pose_x_ff  <= pose_x_in;
         pose_y_ff  <= pose_y_in;
         heading_ff <= heading_in;
         lin_ff     <= lin_in;
         ang_ff     <= ang_in;
         ticks_ff   <= ticks_in;
         hit_ff     <= hit_in;
      end
   end

   // Speed products, CORDIC iterations and displacement products
   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         d_ff  <= 33'(lin_ff) * $signed({17'b0, tick_len_ff});
         ah_ff <= 33'(ang_ff) * $signed({17'b0, tick_len_ff});
      end
      if (ctrl.cdc_init) begin
         cx_ff   <= GainQ16;
         cy_ff   <= '0;
         cz_ff   <= $signed({3'b000, heading_ff[13:0], 12'b0});
         quad_ff <= heading_ff[15:14];
         step_ff <= '0;
      end else if (ctrl.cdc_step) begin
         if (cz_ff >= 0) begin
            cx_ff <= cx_ff - cys;
            cy_ff <= cy_ff + cxs;
            cz_ff <= cz_ff - atan_turn(step5);
         end else begin
            cx_ff <= cx_ff + cys;
            cy_ff <= cy_ff - cxs;
            cz_ff <= cz_ff + atan_turn(step5);
         end
         step_ff <= step_ff + 1'b1;
      end
      if (ctrl.prod) begin
         px_ff <= 54'(d_ff) * 54'(cos_v);
         py_ff <= 54'(d_ff) * 54'(sin_v);
      end
   end

   // Load response register
   always_ff @(posedge clock) begin
      if (ctrl.show) begin
         rsp_x_out         <= pose_x_ff;
         rsp_y_out         <= pose_y_ff;
         rsp_heading_out   <= heading_ff;
         rsp_lin_speed_out <= lin_ff;
         rsp_ang_speed_out <= ang_ff;
         rsp_moving        <= (ticks_ff != '0);
         rsp_wall_hit      <= hit_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_pose_in_box: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.pose) |-> (pose_x_ff <= area_w_ff && pose_y_ff <= area_h_ff))
      else $error("pose outside sandbox");
   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      ctrl.pose |=> (ticks_ff == $past(ticks_ff) - 16'd1))
      else $error("countdown slip");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      ctrl.cdc_step |-> (step_ff < StepBits'(CordicSteps)))
      else $error("CORDIC overrun");
`endif
endmodule

// File: src/planar_pose_integrator.sv
// Top level of the planar pose integrator.
// Place, set-motion, idle-tick and unused commands: beat applied in ST_IDLE, then ST_RESP.
// Moving tick: 1 multiply, 14 CORDIC iterations, 1 product, 1 pose update, then ST_RESP;
// a new beat is taken only in ST_IDLE; ST_RESP waits while an earlier response is unread.
// Synchronous reset clears the pose, speeds and countdown and loads the register defaults.
module planar_pose_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [15:0] req_heading_in,
   input  logic signed [15:0] req_lin_speed_in,
   input  logic signed [15:0] req_ang_speed_in,
   input  logic [15:0] req_duration_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [14:0] rsp_x_out,
   output logic [14:0] rsp_y_out,
   output logic [15:0] rsp_heading_out,
   output logic signed [15:0] rsp_lin_speed_out,
   output logic signed [15:0] rsp_ang_speed_out,
   output logic        rsp_moving,
   output logic        rsp_wall_hit
);
   import ppi_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   assign csr_ready = 1'b1;

   ppi_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .ctrl
   );

   ppi_dp u_dp (
      .clock, .reset, .ctrl, .stat, .csr_valid, .csr_index, .csr_data,
      .req_command, .req_pos_x, .req_pos_y, .req_heading_in,
      .req_lin_speed_in, .req_ang_speed_in, .req_duration_ticks,
      .rsp_x_out, .rsp_y_out, .rsp_heading_out, .rsp_lin_speed_out,
      .rsp_ang_speed_out, .rsp_moving, .rsp_wall_hit
   );
endmodule
